/* sv/wmhp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmhp_pkg
// Shared types and constants for the MAC header parser: role and status codes,
// header layout positions and the address role table.
// ----------------------------------------------------------------------------
package wmhp_pkg;

    // role tag attached to every byte
    typedef enum logic [3:0] {
        ROLE_FC          = 4'd0,
        ROLE_DURATION    = 4'd1,
        ROLE_DEST        = 4'd2,
        ROLE_SRC         = 4'd3,
        ROLE_BSSID       = 4'd4,
        ROLE_RECEIVER    = 4'd5,
        ROLE_TRANSMITTER = 4'd6,
        ROLE_SEQCTL      = 4'd7,
        ROLE_PAYLOAD     = 4'd8
    } t_role;

    // end-of-frame status
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_RUNT     = 2'd1,
        STATUS_NO_ADDR4 = 2'd2
    } t_status;

    // per-byte tag from the classifier
    typedef struct packed {
        t_role      role;
        logic [2:0] offset;
        t_status    status;
    } t_tag;

    localparam int unsigned POS_W = 5;

    // header layout, in byte positions
    localparam logic [POS_W-1:0] POS_DS_BYTE   = 5'd1;
    localparam logic [POS_W-1:0] POS_DURATION  = 5'd2;
    localparam logic [POS_W-1:0] POS_ADDR_BASE = 5'd4;
    localparam logic [POS_W-1:0] POS_SEQCTL    = 5'd22;
    localparam logic [POS_W-1:0] POS_ADDR4     = 5'd24;
    localparam logic [POS_W-1:0] POS_PAYLOAD4  = 5'd30;
    localparam logic [POS_W-1:0] POS_MAX       = 5'd31;
    localparam logic [POS_W-1:0] ADDR_LEN      = 5'd6;

    // minimum header lengths for the status check
    localparam logic [POS_W:0] MIN_HDR_LEN   = 6'd24;
    localparam logic [POS_W:0] ADDR4_HDR_LEN = 6'd30;

    // ToDS and FromDS both set
    localparam logic [1:0] DS_FOUR_ADDR = 2'b11;

    // address role by ds mode (bit 0 ToDS, bit 1 FromDS) and address slot
    function automatic t_role addr_role(input logic [1:0] ds, input logic [1:0] slot);
        t_role r;
        r = ROLE_PAYLOAD;
        case (ds)
            2'd0: begin
                case (slot)
                    2'd0:    r = ROLE_DEST;
                    2'd1:    r = ROLE_SRC;
                    2'd2:    r = ROLE_BSSID;
                    default: r = ROLE_PAYLOAD;
                endcase
            end
            2'd1: begin
                case (slot)
                    2'd0:    r = ROLE_BSSID;
                    2'd1:    r = ROLE_SRC;
                    2'd2:    r = ROLE_DEST;
                    default: r = ROLE_PAYLOAD;
                endcase
            end
            2'd2: begin
                case (slot)
                    2'd0:    r = ROLE_DEST;
                    2'd1:    r = ROLE_BSSID;
                    2'd2:    r = ROLE_SRC;
                    default: r = ROLE_PAYLOAD;
                endcase
            end
            default: begin
                case (slot)
                    2'd0:    r = ROLE_RECEIVER;
                    2'd1:    r = ROLE_TRANSMITTER;
                    2'd2:    r = ROLE_DEST;
                    default: r = ROLE_SRC;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

/* sv/wmhp_classify.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmhp_classify
// Maps a byte position and ds mode to a role, an offset within the field and,
// on the last byte, a length status.
// ----------------------------------------------------------------------------
module wmhp_classify (
    input  logic [wmhp_pkg::POS_W-1:0] i_pos,
    input  logic [1:0]                 i_ds,
    input  logic                       i_last,
    output wmhp_pkg::t_tag             o_tag
);

    logic [wmhp_pkg::POS_W-1:0] rel;
    logic [wmhp_pkg::POS_W-1:0] diff;
    logic [1:0]                 slot;
    logic [wmhp_pkg::POS_W:0]   len;
    wmhp_pkg::t_role            tag_role;
    logic [2:0]                 tag_offset;
    wmhp_pkg::t_status          tag_status;

    // position relative to the first address
    assign rel = i_pos - wmhp_pkg::POS_ADDR_BASE;
    assign len = {1'b0, i_pos} + 6'd1;

    // split the three-address region into slot and offset
    always_comb begin
        if (rel < wmhp_pkg::ADDR_LEN) begin
            slot = 2'd0;
            diff = rel;
        end else if (rel < (wmhp_pkg::ADDR_LEN << 1)) begin
            slot = 2'd1;
            diff = rel - wmhp_pkg::ADDR_LEN;
        end else begin
            slot = 2'd2;
            diff = rel - (wmhp_pkg::ADDR_LEN << 1);
        end
    end

    // role and offset by header region
    always_comb begin
        if (i_pos < wmhp_pkg::POS_DURATION) begin
            tag_role   = wmhp_pkg::ROLE_FC;
            tag_offset = i_pos[2:0];
        end else if (i_pos < wmhp_pkg::POS_ADDR_BASE) begin
            tag_role   = wmhp_pkg::ROLE_DURATION;
            tag_offset = 3'(i_pos - wmhp_pkg::POS_DURATION);
        end else if (i_pos < wmhp_pkg::POS_SEQCTL) begin
            tag_role   = wmhp_pkg::addr_role(i_ds, slot);
            tag_offset = diff[2:0];
        end else if (i_pos < wmhp_pkg::POS_ADDR4) begin
            tag_role   = wmhp_pkg::ROLE_SEQCTL;
            tag_offset = 3'(i_pos - wmhp_pkg::POS_SEQCTL);
        end else if (i_pos < wmhp_pkg::POS_PAYLOAD4 && i_ds == wmhp_pkg::DS_FOUR_ADDR) begin
            tag_role   = wmhp_pkg::addr_role(i_ds, 2'd3);
            tag_offset = 3'(i_pos - wmhp_pkg::POS_ADDR4);
        end else begin
            tag_role   = wmhp_pkg::ROLE_PAYLOAD;
            tag_offset = 3'd0;
        end
    end

    // length status, runt test first
    always_comb begin
        tag_status = wmhp_pkg::STATUS_OK;
        if (i_last) begin
            if (len < wmhp_pkg::MIN_HDR_LEN) begin
                tag_status = wmhp_pkg::STATUS_RUNT;
            end else if (i_ds == wmhp_pkg::DS_FOUR_ADDR && len < wmhp_pkg::ADDR4_HDR_LEN) begin
                tag_status = wmhp_pkg::STATUS_NO_ADDR4;
            end
        end
    end

    assign o_tag = '{role: tag_role, offset: tag_offset, status: tag_status};

endmodule

/* sv/wifi_mac_header_parser_unit.sv */
`timescale 1ns / 1ps
// Pipeline: an accepted byte is captured in the input register and classified,
// and its result is loaded into the output register.
// Throughput: one byte per cycle while i_out_ready is high; the input register
// and the output register each advance whenever the stage after them is free.
// Reset: synchronous, active low; clears the byte position, ds mode and all
// valid flags, so the next byte is taken as frame byte 0.
// ----------------------------------------------------------------------------
// wifi_mac_header_parser_unit
// Tags each byte of an 802.11 MAC frame with its header role and field offset
// and reports a length status on the frame's last byte.
// ----------------------------------------------------------------------------
module wifi_mac_header_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_byte_out,
    output logic [3:0] o_role,
    output logic [2:0] o_field_offset,
    output logic       o_frame_end,
    output logic [1:0] o_status
);

    // frame tracking state
    logic [wmhp_pkg::POS_W-1:0] r_pos;
    logic [wmhp_pkg::POS_W-1:0] n_pos;
    logic [1:0]                 r_ds;
    logic [1:0]                 n_ds;
    logic [1:0]                 ds_now;

    // input register
    logic                       r_s1_valid;
    logic [7:0]                 r_s1_byte;
    logic                       r_s1_last;
    logic [wmhp_pkg::POS_W-1:0] r_s1_pos;
    logic [1:0]                 r_s1_ds;

    // result register
    logic                       r_out_valid;
    logic [7:0]                 r_out_byte;
    logic                       r_out_last;
    wmhp_pkg::t_tag             r_out_tag;

    wmhp_pkg::t_tag             s1_tag;
    logic                       s1_ready;
    logic                       s2_ready;
    logic                       in_fire;

    // pipeline flow control
    assign s2_ready   = !r_out_valid || i_out_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_ready = s1_ready;
    assign in_fire    = i_in_valid && s1_ready;

    // ds bits come from frame byte 1 and apply to that byte already
    assign ds_now = (r_pos == wmhp_pkg::POS_DS_BYTE) ? i_data_byte[1:0] : r_ds;

    // next position and ds mode
    always_comb begin
        n_pos = r_pos;
        n_ds  = r_ds;
        if (in_fire) begin
            if (i_last_byte) begin
                n_pos = '0;
                n_ds  = '0;
            end else begin
                n_ds = ds_now;
                if (r_pos < wmhp_pkg::POS_MAX) begin
                    n_pos = r_pos + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ds  <= '0;
        end else begin
            r_pos <= n_pos;
            r_ds  <= n_ds;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
        if (in_fire) begin
            r_s1_byte <= i_data_byte;
            r_s1_last <= i_last_byte;
            r_s1_pos  <= r_pos;
            r_s1_ds   <= ds_now;
        end
    end

    // byte classification
    wmhp_classify u_classify (
        .i_pos  (r_s1_pos),
        .i_ds   (r_s1_ds),
        .i_last (r_s1_last),
        .o_tag  (s1_tag)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_ready) begin
            r_out_valid <= r_s1_valid;
        end
        if (s2_ready && r_s1_valid) begin
            r_out_byte <= r_s1_byte;
            r_out_last <= r_s1_last;
            r_out_tag  <= s1_tag;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_out     = r_out_byte;
    assign o_role         = r_out_tag.role;
    assign o_field_offset = r_out_tag.offset;
    assign o_frame_end    = r_out_last;
    assign o_status       = r_out_tag.status;

    // a last byte sends tracking back to frame start
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_last_byte |=> r_pos == '0 && r_ds == '0)
        else $error("position not cleared after last byte");

    // ds mode is only known once byte 1 has gone by
    a_ds_after_byte1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ds != '0 |-> r_pos > wmhp_pkg::POS_DS_BYTE)
        else $error("ds mode set before frame byte 1");

    // a nonzero status only comes with the frame end
    a_status_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != wmhp_pkg::STATUS_OK |-> o_frame_end)
        else $error("status reported on a non-final byte");

    // payload bytes carry no offset
    a_payload_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_role == wmhp_pkg::ROLE_PAYLOAD |-> o_field_offset == 3'd0)
        else $error("payload byte with nonzero offset");

endmodule
